// ----- hw/rtl/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// Types and constants shared by the sorted free-list slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

  localparam int unsigned MAX_SLOTS = 256;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned LINK_W    = 9;
  localparam int unsigned LINK_DEPTH = MAX_SLOTS + 1;
  localparam int unsigned VALUE_W   = 32;

  // A link value that no slot index can take.
  localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(MAX_SLOTS + 1);
  localparam logic [LINK_W-1:0] SLOT_LAST = LINK_W'(MAX_SLOTS);

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  // Register select is the word address, paddr[2].
  localparam logic        REG_SLOT_CAP   = 1'b0;
  localparam logic [CNT_W-1:0] SLOT_CAP_RESET = CNT_W'(256);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BEYOND = 2'd2,
    ST_FREE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_WALK,
    S_WAIT,
    S_DEL2,
    S_GET,
    S_EMIT
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   slot_index;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot_index_res;
    logic [VALUE_W-1:0] value_res;
    logic [CNT_W-1:0]   occupied_count;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfa_in_if.sv -----
// ----------------------------------------------------------------------------
// sfa_in_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfa_in_if;
  logic             valid;
  logic             ready;
  sfa_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sfa_out_if.sv -----
// ----------------------------------------------------------------------------
// sfa_out_if
// Response channel: valid/ready handshake carrying one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfa_out_if;
  logic              valid;
  logic              ready;
  sfa_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sfa_ram.sv -----
// ----------------------------------------------------------------------------
// sfa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_free_list_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// sorted_free_list_slot_allocator_core
// Slot table with a free list chained in ascending index order.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one request word (mode, slot_index, value); out_ch returns
//   exactly one response word per request. Insert stores the value in the
//   lowest free slot; delete links a slot back into the sorted free list;
//   get returns the stored payload. The APB port holds the slot limit at 0x0.
// Timing:
//   A request is worked on alone; in_ch.ready is high while the engine idles.
//   A delete or get walks the free list from its head; each step of the walk
//   is one read of the link memory. A get of a slot in use adds a payload
//   read and a delete behind an earlier free node adds a second link write.
//   An out-of-range request or a no-op is answered without a memory access.
// Reset:
//   Synchronous, active low. The list empties, the high-water mark and the
//   count go to zero and the slot limit returns to 256. No clearing pass.
// Back-pressure:
//   The response stays in the output register while out_ch.ready is low; the
//   next request is taken meanwhile and its response waits until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_free_list_slot_allocator_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  sfa_in_if.sink                                  in_ch,
  sfa_out_if.source                               out_ch,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sfa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [sfa_pkg::CFG_DATA_W-1:0]     pwdata,
  output      logic [sfa_pkg::CFG_DATA_W-1:0]     prdata,
  output      logic                               pready
);

  localparam int unsigned LW = sfa_pkg::LINK_W;
  localparam int unsigned IW = sfa_pkg::IDX_W;
  localparam int unsigned CW = sfa_pkg::CNT_W;
  localparam int unsigned VW = sfa_pkg::VALUE_W;
  localparam int unsigned LINK_AW = $clog2(sfa_pkg::LINK_DEPTH);
  localparam int unsigned PAY_AW  = $clog2(sfa_pkg::MAX_SLOTS);

  sfa_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] hw_r, hw_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] slot_cap_r, slot_cap_nxt;
  logic          link0_wr_r, link0_wr_nxt;
  logic          rd0_r;

  sfa_pkg::mode_t op_mode_r, op_mode_nxt;
  logic [IW-1:0]  op_idx_r, op_idx_nxt;
  logic [LW-1:0]  cur_r, cur_nxt;
  logic [LW-1:0]  prev_r, prev_nxt;
  logic           has_prev_r, has_prev_nxt;

  sfa_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]    res_idx_r, res_idx_nxt;
  logic [VW-1:0]    res_val_r, res_val_nxt;

  logic               out_valid_r, out_valid_nxt;
  sfa_pkg::out_word_t out_word_r, out_word_nxt;

  // Memory ports
  logic                  link_we;
  logic [LINK_AW-1:0]    link_waddr, link_raddr;
  logic [LW-1:0]         link_wdata, link_q, link_rd;
  logic                  pay_we;
  logic [PAY_AW-1:0]     pay_waddr, pay_raddr;
  logic [DATA_WIDTH-1:0] pay_wdata, pay_q;
  logic [DATA_WIDTH+VW-1:0] pay_wide_in, pay_wide_out;

  logic          in_acc;
  logic          emit_free;
  logic [CW-1:0] limit;
  logic          ins_fail;
  logic          head_is_hw;
  logic          idx_beyond;
  logic          walk_hit;
  logic          walk_match;
  logic          cfg_wr;

  sfa_ram #(.WIDTH(LW), .DEPTH(sfa_pkg::LINK_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_q)
  );

  sfa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(sfa_pkg::MAX_SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .raddr (pay_raddr),
    .rdata (pay_q)
  );

  // Entry zero of the link memory reads as the end marker until first written.
  assign link_rd = (rd0_r && !link0_wr_r) ? sfa_pkg::LINK_END : link_q;

  assign pay_wide_in  = {{DATA_WIDTH{1'b0}}, in_ch.data.value};
  assign pay_wdata    = pay_wide_in[DATA_WIDTH-1:0];
  assign pay_wide_out = {{VW{1'b0}}, pay_q};

  assign in_ch.ready  = (state_r == sfa_pkg::S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign emit_free    = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  assign limit      = (slot_cap_r > CW'(sfa_pkg::MAX_SLOTS)) ? CW'(sfa_pkg::MAX_SLOTS)
                                                             : slot_cap_r;
  assign ins_fail   = (used_r >= limit) || (head_r >= sfa_pkg::SLOT_LAST);
  assign head_is_hw = (head_r == hw_r);
  assign idx_beyond = ({1'b0, in_ch.data.slot_index} >= hw_r);
  assign walk_hit   = (cur_r >= {1'b0, op_idx_r});
  assign walk_match = (cur_r == {1'b0, op_idx_r});

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == sfa_pkg::REG_SLOT_CAP);
  assign slot_cap_nxt = cfg_wr ? pwdata[CW-1:0] : slot_cap_r;

  always_comb begin
    prdata = '0;
    if (paddr[2] == sfa_pkg::REG_SLOT_CAP) begin
      prdata = {{(sfa_pkg::CFG_DATA_W-CW){1'b0}}, slot_cap_r};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfa_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.data.mode)
            sfa_pkg::MODE_INSERT: begin
              state_nxt = (ins_fail || head_is_hw) ? sfa_pkg::S_EMIT : sfa_pkg::S_INS;
            end
            sfa_pkg::MODE_DELETE,
            sfa_pkg::MODE_GET: begin
              state_nxt = idx_beyond ? sfa_pkg::S_EMIT : sfa_pkg::S_WALK;
            end
            sfa_pkg::MODE_NOP: begin
              state_nxt = sfa_pkg::S_EMIT;
            end
          endcase
        end
      end
      sfa_pkg::S_INS: begin
        state_nxt = sfa_pkg::S_EMIT;
      end
      sfa_pkg::S_WALK: begin
        if (!walk_hit) begin
          state_nxt = sfa_pkg::S_WAIT;
        end else if (walk_match) begin
          state_nxt = sfa_pkg::S_EMIT;
        end else if (op_mode_r == sfa_pkg::MODE_DELETE) begin
          state_nxt = has_prev_r ? sfa_pkg::S_DEL2 : sfa_pkg::S_EMIT;
        end else begin
          state_nxt = sfa_pkg::S_GET;
        end
      end
      sfa_pkg::S_WAIT: begin
        state_nxt = sfa_pkg::S_WALK;
      end
      sfa_pkg::S_DEL2: begin
        state_nxt = sfa_pkg::S_EMIT;
      end
      sfa_pkg::S_GET: begin
        state_nxt = sfa_pkg::S_EMIT;
      end
      sfa_pkg::S_EMIT: begin
        if (emit_free) begin
          state_nxt = sfa_pkg::S_IDLE;
        end
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    head_nxt       = head_r;
    hw_nxt         = hw_r;
    used_nxt       = used_r;
    op_mode_nxt    = op_mode_r;
    op_idx_nxt     = op_idx_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    has_prev_nxt   = has_prev_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_word_nxt   = out_word_r;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;
    link_raddr     = '0;
    pay_we         = 1'b0;
    pay_waddr      = '0;
    pay_raddr      = '0;

    unique case (state_r)
      sfa_pkg::S_IDLE: begin
        if (in_acc) begin
          op_mode_nxt    = in_ch.data.mode;
          op_idx_nxt     = in_ch.data.slot_index;
          res_idx_nxt    = in_ch.data.slot_index;
          res_val_nxt    = '0;
          res_status_nxt = sfa_pkg::ST_OK;
          cur_nxt        = head_r;
          prev_nxt       = '0;
          has_prev_nxt   = 1'b0;
          unique case (in_ch.data.mode)
            sfa_pkg::MODE_INSERT: begin
              if (ins_fail) begin
                res_status_nxt = sfa_pkg::ST_FULL;
                res_idx_nxt    = '0;
              end else begin
                pay_we      = 1'b1;
                pay_waddr   = head_r[PAY_AW-1:0];
                used_nxt    = used_r + CW'(1);
                res_idx_nxt = head_r[IW-1:0];
                if (head_is_hw) begin
                  // The list held only the mark: the mark moves up and ends it.
                  hw_nxt     = head_r + LW'(1);
                  head_nxt   = head_r + LW'(1);
                  link_we    = 1'b1;
                  link_waddr = LINK_AW'(head_r + LW'(1));
                  link_wdata = sfa_pkg::LINK_END;
                end else begin
                  link_raddr = LINK_AW'(head_r);
                end
              end
            end
            sfa_pkg::MODE_DELETE,
            sfa_pkg::MODE_GET: begin
              if (idx_beyond) begin
                res_status_nxt = sfa_pkg::ST_BEYOND;
              end
            end
            sfa_pkg::MODE_NOP: begin
            end
          endcase
        end
      end
      sfa_pkg::S_INS: begin
        head_nxt = link_rd;
      end
      sfa_pkg::S_WALK: begin
        if (!walk_hit) begin
          link_raddr   = LINK_AW'(cur_r);
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
        end else if (walk_match) begin
          res_status_nxt = sfa_pkg::ST_FREE;
        end else if (op_mode_r == sfa_pkg::MODE_DELETE) begin
          link_we    = 1'b1;
          link_waddr = LINK_AW'(op_idx_r);
          link_wdata = cur_r;
          if (!has_prev_r) begin
            head_nxt = {1'b0, op_idx_r};
          end
          if (used_r != '0) begin
            used_nxt = used_r - CW'(1);
          end
        end else begin
          pay_raddr = op_idx_r[PAY_AW-1:0];
        end
      end
      sfa_pkg::S_WAIT: begin
        cur_nxt = link_rd;
      end
      sfa_pkg::S_DEL2: begin
        link_we    = 1'b1;
        link_waddr = LINK_AW'(prev_r);
        link_wdata = {1'b0, op_idx_r};
      end
      sfa_pkg::S_GET: begin
        res_val_nxt = pay_wide_out[VW-1:0];
      end
      sfa_pkg::S_EMIT: begin
        if (emit_free) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.status         = res_status_r;
          out_word_nxt.slot_index_res = res_idx_r;
          out_word_nxt.value_res      = res_val_r;
          out_word_nxt.occupied_count = used_r;
        end
      end
    endcase
  end

  assign link0_wr_nxt = link0_wr_r || (link_we && (link_waddr == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfa_pkg::S_IDLE;
      head_r      <= '0;
      hw_r        <= '0;
      used_r      <= '0;
      slot_cap_r  <= sfa_pkg::SLOT_CAP_RESET;
      link0_wr_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      hw_r        <= hw_nxt;
      used_r      <= used_nxt;
      slot_cap_r  <= slot_cap_nxt;
      link0_wr_r  <= link0_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd0_r        <= (link_raddr == '0);
    op_mode_r    <= op_mode_nxt;
    op_idx_r     <= op_idx_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    has_prev_r   <= has_prev_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_val_r    <= res_val_nxt;
    out_word_r   <= out_word_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfa_checker.sv -----
// ----------------------------------------------------------------------------
// sfa_checker
// Port-level checks on the slot allocator's response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sfa_pkg::out_word_t out_data
);

  // A response word is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response word changed or dropped while stalled");

  // The count can never exceed the table size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.occupied_count <= 9'(sfa_pkg::MAX_SLOTS))
    else $error("occupied count beyond table size");

  // A failed insert reports slot zero.
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == sfa_pkg::ST_FULL) |-> out_data.slot_index_res == '0)
    else $error("failed insert with non-zero slot");

  // Only a successful operation may return a payload.
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != sfa_pkg::ST_OK) |-> out_data.value_res == '0)
    else $error("payload returned with an error status");

endmodule

bind sorted_free_list_slot_allocator_core sfa_checker u_sfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

// ----- tb/tb_sorted_free_list_slot_allocator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_free_list_slot_allocator_core
// Self-checking bench for the sorted free-list slot allocator.
// A queue of request words feeds a clocked driver. Each accepted word runs
// through a local model of the slot table, which leaves one expected
// response. A clocked monitor compares each response with the oldest
// expectation. Runs of random words fill, churn and empty the table between
// changes of the slot limit. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------

module tb_sorted_free_list_slot_allocator_core;
  import sfa_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 600;
  localparam int PHASE_WORDS  = 520;

  typedef enum {MIX_FILL, MIX_CHURN, MIX_EMPTY} mix_t;

  logic clk;
  logic rst_n = 1'b0;

  // APB side, driven only by the main initial block.
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic     req_valid = 1'b0;
  in_word_t req_word  = '0;
  logic     rsp_ready = 1'b0;

  sfa_in_if  req_if ();
  sfa_out_if rsp_if ();

  assign req_if.valid = req_valid;
  assign req_if.data  = req_word;
  assign rsp_if.ready = rsp_ready;

  sorted_free_list_slot_allocator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_if),
    .out_ch  (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the slot table.
  logic [LINK_W-1:0]  nxt_free  [LINK_DEPTH];
  logic [VALUE_W-1:0] slot_data [MAX_SLOTS];
  logic               slot_busy [MAX_SLOTS];
  logic [LINK_W-1:0]  head_slot;
  logic [LINK_W-1:0]  mark;
  logic [CNT_W-1:0]   in_use;
  logic [CNT_W-1:0]   limit_reg;

  in_word_t  request_queue [$];
  out_word_t pending_responses [$];
  int        words_queued = 0;
  int        words_taken  = 0;
  int        error_count  = 0;
  int        quiet_cycles = 0;
  int        send_gap_pct   = 0;
  int        recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_table();
    int k;
    for (k = 0; k < LINK_DEPTH; k++) nxt_free[k] = '0;
    for (k = 0; k < MAX_SLOTS; k++) begin
      slot_data[k] = '0;
      slot_busy[k] = 1'b0;
    end
    nxt_free[0] = LINK_END;
    head_slot   = '0;
    mark        = '0;
    in_use      = '0;
    limit_reg   = SLOT_CAP_RESET;
  endfunction

  // Applies one request word to the local table and returns its response.
  function automatic out_word_t predict_response(input in_word_t w);
    out_word_t         r;
    logic [LINK_W-1:0] node;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] slot;
    logic [LINK_W-1:0] want;
    logic              has_prev;
    logic              done;
    int unsigned       lim;
    int                steps;
    r.status         = ST_OK;
    r.slot_index_res = w.slot_index;
    r.value_res      = '0;
    want             = {1'b0, w.slot_index};
    case (w.mode)
      MODE_INSERT: begin
        lim = (limit_reg > MAX_SLOTS) ? MAX_SLOTS : limit_reg;
        if (in_use >= lim || head_slot >= MAX_SLOTS) begin
          r.status         = ST_FULL;
          r.slot_index_res = '0;
        end else begin
          slot = head_slot;
          if (slot == mark) begin
            // The mark moves up and becomes the new end of the chain.
            mark           = slot + LINK_W'(1);
            head_slot      = slot + LINK_W'(1);
            nxt_free[mark] = LINK_END;
          end else begin
            head_slot = nxt_free[slot];
          end
          slot_data[slot[IDX_W-1:0]] = w.value;
          slot_busy[slot[IDX_W-1:0]] = 1'b1;
          in_use                     = in_use + CNT_W'(1);
          r.slot_index_res           = slot[IDX_W-1:0];
        end
      end
      MODE_DELETE, MODE_GET: begin
        if (want >= mark) begin
          r.status = ST_BEYOND;
        end else begin
          node     = head_slot;
          prev     = '0;
          has_prev = 1'b0;
          done     = 1'b0;
          steps    = 0;
          while (!done && steps <= MAX_SLOTS) begin
            steps++;
            if (node > SLOT_LAST) begin
              done = 1'b1;
            end else if (nxt_free[node] == LINK_END || want <= node) begin
              done = 1'b1;
            end else begin
              prev     = node;
              has_prev = 1'b1;
              node     = nxt_free[node];
            end
          end
          if (node == want) begin
            r.status = ST_FREE;
          end else if (w.mode == MODE_DELETE) begin
            if (has_prev) nxt_free[prev] = want;
            else head_slot = want;
            nxt_free[want]           = node;
            slot_busy[w.slot_index]  = 1'b0;
            if (in_use > 0) in_use   = in_use - CNT_W'(1);
          end else begin
            r.value_res = slot_data[w.slot_index];
          end
        end
      end
      default: begin
      end
    endcase
    r.occupied_count = in_use;
    return r;
  endfunction

  // Driver: a new word goes out once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) begin
        pending_responses.push_back(predict_response(req_word));
        words_taken++;
      end
      if (!req_valid || req_if.ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          req_word  <= request_queue.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every response word is checked against the oldest expectation.
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t got_w;
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        got_w = rsp_if.data;
        if (pending_responses.size() == 0) begin
          $display("%0t: unexpected response: got status %0d slot %0d value %h count %0d",
                   $time, got_w.status, got_w.slot_index_res, got_w.value_res,
                   got_w.occupied_count);
          error_count++;
        end else begin
          exp_w = pending_responses.pop_front();
          if (got_w.status !== exp_w.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_w.status, got_w.status);
            error_count++;
          end
          if (got_w.slot_index_res !== exp_w.slot_index_res) begin
            $display("%0t: slot_index_res mismatch: expected %0d, actual %0d",
                     $time, exp_w.slot_index_res, got_w.slot_index_res);
            error_count++;
          end
          if (got_w.value_res !== exp_w.value_res) begin
            $display("%0t: value_res mismatch: expected %h, actual %h",
                     $time, exp_w.value_res, got_w.value_res);
            error_count++;
          end
          if (got_w.occupied_count !== exp_w.occupied_count) begin
            $display("%0t: occupied_count mismatch: expected %0d, actual %0d",
                     $time, exp_w.occupied_count, got_w.occupied_count);
            error_count++;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on stretches in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_if.ready) || (rsp_if.valid && rsp_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** sorted_free_list_slot_allocator_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_word(input mode_t m, input logic [IDX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val);
    in_word_t w;
    w.mode       = m;
    w.slot_index = idx;
    w.value      = val;
    request_queue.push_back(w);
    words_queued++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_payload();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // The sender holds off until every word sent so far has been answered.
  task automatic wait_drained();
    @(negedge clk);
    while (words_taken != words_queued || pending_responses.size() != 0) @(negedge clk);
  endtask

  task automatic write_slot_cap(input logic [CNT_W-1:0] sz);
    logic [CFG_DATA_W-1:0] data;
    data        = $urandom;
    data[CNT_W-1:0] = sz;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SLOT_CAP, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_reg = sz;
  endtask

  task automatic gen_chunk(input mix_t mix, input int count);
    int               busy_list [$];
    int               k;
    int               r;
    logic [IDX_W-1:0] idx;
    for (k = 0; k < MAX_SLOTS; k++) if (slot_busy[k]) busy_list.push_back(k);
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      // Mostly aim at slots that are in use, so that walks go deep.
      if (busy_list.size() > 0 && $urandom_range(9) != 0)
        idx = busy_list[$urandom_range(busy_list.size() - 1)];
      else
        idx = $urandom_range(255);
      case (mix)
        MIX_FILL: queue_word(MODE_INSERT, $urandom_range(255), pick_payload());
        MIX_CHURN: begin
          if (r < 40) queue_word(MODE_INSERT, $urandom_range(255), pick_payload());
          else if (r < 65) queue_word(MODE_DELETE, idx, $urandom);
          else if (r < 85) queue_word(MODE_GET, idx, $urandom);
          else if (r < 95) queue_word(mode_t'($urandom_range(1, 2)), $urandom_range(255),
                                      $urandom);
          else queue_word(mode_t'($urandom_range(3)), $urandom_range(255), $urandom);
        end
        default: begin
          if (r < 65) queue_word(MODE_DELETE, idx, $urandom);
          else if (r < 90) queue_word(MODE_GET, idx, $urandom);
          else if (r < 96) queue_word(MODE_INSERT, $urandom_range(255), pick_payload());
          else queue_word(mode_t'($urandom_range(3)), $urandom_range(255), $urandom);
        end
      endcase
    end
  endtask

  task automatic run_phase(input int target);
    int start;
    int pick;
    start = words_queued;
    write_slot_cap($urandom_range(1) ? CNT_W'(256) : CNT_W'(511));
    gen_chunk(MIX_FILL, MAX_SLOTS - in_use + 3);
    wait_drained();
    while (words_queued - start < target) begin
      if ($urandom_range(2) == 0) begin
        pick = $urandom_range(5);
        case (pick)
          0: write_slot_cap(CNT_W'(0));
          1: write_slot_cap(CNT_W'(1));
          2: write_slot_cap(CNT_W'(256));
          3: write_slot_cap(CNT_W'(511));
          4: write_slot_cap(in_use);
          default: write_slot_cap(CNT_W'($urandom_range(1, 256)));
        endcase
      end
      pick = $urandom_range(9);
      gen_chunk(pick < 5 ? MIX_CHURN : (pick < 8 ? MIX_EMPTY : MIX_FILL),
                $urandom_range(20, 60));
      wait_drained();
    end
  endtask

  initial begin
    reset_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 24;
    recv_stall_pct = 51;

    // Directed words on the empty table and a few slots.
    queue_word(MODE_GET,    8'd0,   32'h0);
    queue_word(MODE_DELETE, 8'd255, 32'h0);
    queue_word(MODE_NOP,    8'hAB,  32'h1234_5678);
    queue_word(MODE_INSERT, 8'hFF,  32'h0000_0000);
    queue_word(MODE_INSERT, 8'h00,  32'hFFFF_FFFF);
    queue_word(MODE_INSERT, 8'h55,  32'hA5A5_A5A5);
    queue_word(MODE_GET,    8'd1,   32'h0);
    queue_word(MODE_GET,    8'd0,   32'hFFFF_FFFF);
    queue_word(MODE_DELETE, 8'd1,   32'h0);
    queue_word(MODE_GET,    8'd1,   32'h0);
    queue_word(MODE_DELETE, 8'd1,   32'h0);
    queue_word(MODE_DELETE, 8'd0,   32'h0);
    queue_word(MODE_INSERT, 8'd0,   32'h0F0F_0F0F);
    queue_word(MODE_INSERT, 8'd0,   32'hF0F0_F0F0);
    queue_word(MODE_GET,    8'd3,   32'h0);
    queue_word(MODE_DELETE, 8'd2,   32'h0);
    queue_word(MODE_DELETE, 8'd1,   32'h0);
    queue_word(MODE_GET,    8'd2,   32'h0);
    queue_word(MODE_INSERT, 8'd0,   32'h8000_0001);
    queue_word(MODE_INSERT, 8'd0,   32'h7FFF_FFFE);
    queue_word(MODE_GET,    8'd2,   32'h0);
    wait_drained();

    // A limit below the count refuses inserts but keeps the slots in use.
    write_slot_cap(CNT_W'(1));
    queue_word(MODE_INSERT, 8'd0, 32'hDEAD_BEEF);
    queue_word(MODE_GET,    8'd1, 32'h0);
    wait_drained();
    write_slot_cap(CNT_W'(0));
    queue_word(MODE_INSERT, 8'd0, 32'hDEAD_BEEF);
    wait_drained();

    run_phase(PHASE_WORDS);

    send_gap_pct   = 51;
    recv_stall_pct = 24;
    run_phase(PHASE_WORDS);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(PHASE_WORDS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("** sorted_free_list_slot_allocator_core: PASSED **");
    end else begin
      $display("** sorted_free_list_slot_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
